FILE: sv/dwls_pkg.sv
// Shared types and constants for the double-ended queue with linear search.
// No dependencies; used by deque_with_linear_search and dwls_chk.
package dwls_pkg;

   // Queue geometry
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int SUM_W       = $clog2(2 * DEPTH);

   // Port field widths
   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = IDX_W;

   // Operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_FIND       = 3'd4
   } func_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [1:0] {
      SQ_IDLE = 2'b01,
      SQ_SCAN = 2'b10
   } state_type;

endpackage

FILE: sv/deque_with_linear_search.sv
// Bounded double-ended queue of signed values with a linear search unit.
// Depends on dwls_pkg (geometry, operation and status codes, states).

// Pushes and pops need no walk, so one such transfer can be taken every cycle
// unless a held result stalls the request side. A find walks the ring store
// from the front through its single registered read port and one equality
// comparator, one entry per cycle. It holds the block until the walk ends on
// a hit or at the last occupied entry; a find on an empty queue is answered
// without a walk, with an empty status.
// req_stall stays high while a find is walking, and also while an unaccepted
// result is being held with rsp_stall high. Results come from an output
// register in the order the requests were taken.
module deque_with_linear_search (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dwls_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [dwls_pkg::DATA_W-1:0] req_value,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [dwls_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_found,
   output logic [dwls_pkg::POS_W-1:0]         rsp_position,
   output logic [dwls_pkg::CNT_W-1:0]         rsp_occupancy
);

   // Ring slot = (base + off) mod DEPTH; off never exceeds DEPTH
   function automatic logic [dwls_pkg::IDX_W-1:0] ring_add(
      input logic [dwls_pkg::IDX_W-1:0] base,
      input logic [dwls_pkg::CNT_W-1:0] off
   );
      logic [dwls_pkg::SUM_W-1:0] s;
      s = dwls_pkg::SUM_W'(base) + dwls_pkg::SUM_W'(off);
      if (s >= dwls_pkg::SUM_W'(dwls_pkg::DEPTH)) begin
         s = s - dwls_pkg::SUM_W'(dwls_pkg::DEPTH);
      end
      return s[dwls_pkg::IDX_W-1:0];
   endfunction

   // Control state
   dwls_pkg::state_type              state_ff, state_in;
   logic [dwls_pkg::IDX_W-1:0]       front_ff, front_in;
   logic [dwls_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [dwls_pkg::CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                             cmp_vld_ff, cmp_vld_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [dwls_pkg::CNT_W-1:0]       cmp_pos_ff, cmp_pos_in;
   logic [dwls_pkg::VALUE_WIDTH-1:0] key_ff, key_in;
   logic [dwls_pkg::VALUE_WIDTH-1:0] rd_data_ff;
   logic [dwls_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                             found_ff, found_in;
   logic [dwls_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [dwls_pkg::CNT_W-1:0]       occ_ff, occ_in;

   // Ring store
   logic [dwls_pkg::VALUE_WIDTH-1:0] mem [dwls_pkg::DEPTH];

   logic                             wr_en, rd_en;
   logic [dwls_pkg::IDX_W-1:0]       wr_addr, rd_addr;
   logic [dwls_pkg::VALUE_WIDTH-1:0] req_data;

   logic rsp_free, req_xfer, full, empty, hit, last;
   logic [dwls_pkg::IDX_W-1:0] dec_front;

   assign req_data  = req_value[dwls_pkg::VALUE_WIDTH-1:0];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != dwls_pkg::SQ_IDLE) || !rsp_free;
   assign req_xfer  = req_valid && !req_stall;
   assign full      = (count_ff == dwls_pkg::CNT_W'(dwls_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign dec_front = ring_add(front_ff, dwls_pkg::CNT_W'(dwls_pkg::DEPTH - 1));
   assign rd_addr   = ring_add(front_ff, rd_idx_ff);

   // The one comparator: the registered entry from the walk's read against the search key
   assign hit  = cmp_vld_ff && (rd_data_ff == key_ff);
   assign last = cmp_vld_ff && ((cmp_pos_ff + dwls_pkg::CNT_W'(1)) == count_ff);

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_pos_in   = cmp_pos_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         dwls_pkg::SQ_IDLE: begin
            if (req_xfer) begin
               status_in    = dwls_pkg::ST_DONE;
               found_in     = 1'b0;
               pos_in       = '0;
               rsp_valid_in = 1'b1;
               unique case (req_func)
                  dwls_pkg::FN_PUSH_FRONT: begin
                     if (full) begin
                        status_in = dwls_pkg::ST_FULL;
                     end else begin
                        front_in = dec_front;
                        wr_en    = 1'b1;
                        wr_addr  = dec_front;
                        count_in = count_ff + dwls_pkg::CNT_W'(1);
                     end
                  end
                  dwls_pkg::FN_PUSH_BACK: begin
                     if (full) begin
                        status_in = dwls_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_add(front_ff, count_ff);
                        count_in = count_ff + dwls_pkg::CNT_W'(1);
                     end
                  end
                  dwls_pkg::FN_POP_FRONT: begin
                     if (empty) begin
                        status_in = dwls_pkg::ST_EMPTY;
                     end else begin
                        front_in = ring_add(front_ff, dwls_pkg::CNT_W'(1));
                        count_in = count_ff - dwls_pkg::CNT_W'(1);
                     end
                  end
                  dwls_pkg::FN_POP_BACK: begin
                     if (empty) begin
                        status_in = dwls_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - dwls_pkg::CNT_W'(1);
                     end
                  end
                  dwls_pkg::FN_FIND: begin
                     if (empty) begin
                        status_in = dwls_pkg::ST_EMPTY;
                     end else begin
                        // start the walk; the result is posted at its end
                        rsp_valid_in = 1'b0;
                        key_in       = req_data;
                        rd_idx_in    = '0;
                        cmp_vld_in   = 1'b0;
                        state_in     = dwls_pkg::SQ_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               occ_in = count_in;
            end
         end
         dwls_pkg::SQ_SCAN: begin
            if (hit || last) begin
               // walk finished; post when the output register frees up
               if (rsp_free) begin
                  status_in    = dwls_pkg::ST_DONE;
                  found_in     = hit;
                  pos_in       = hit ? cmp_pos_ff[dwls_pkg::POS_W-1:0] : '0;
                  occ_in       = count_ff;
                  rsp_valid_in = 1'b1;
                  cmp_vld_in   = 1'b0;
                  state_in     = dwls_pkg::SQ_IDLE;
               end
            end else begin
               // fetch the next entry, compare it next cycle
               rd_en      = 1'b1;
               cmp_pos_in = rd_idx_ff;
               cmp_vld_in = 1'b1;
               rd_idx_in  = rd_idx_ff + dwls_pkg::CNT_W'(1);
            end
         end
         default: begin
            state_in = dwls_pkg::SQ_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwls_pkg::SQ_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_pos_ff <= cmp_pos_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      occ_ff     <= occ_in;
   end

   // Ring store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_found     = found_ff;
   assign rsp_position  = pos_ff;
   assign rsp_occupancy = occ_ff;

endmodule

FILE: sv/dwls_chk.sv
// Port-level checker for deque_with_linear_search, attached by bind.
// Depends on dwls_pkg for the queue depth, field widths, status and operation codes.
module dwls_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [dwls_pkg::FUNC_W-1:0]   req_func,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [dwls_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_found,
   input logic [dwls_pkg::POS_W-1:0]    rsp_position,
   input logic [dwls_pkg::CNT_W-1:0]    rsp_occupancy
);

   // A match is only ever reported with a done status
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == dwls_pkg::ST_DONE)
      else $error("found reported with non-done status");

   // Position is zero unless a match was found, and lies inside the queue
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_found && rsp_position == '0) ||
                    (rsp_found && dwls_pkg::CNT_W'(rsp_position) < rsp_occupancy))
      else $error("position outside the occupied range");

   // A rejected push only happens with the queue full
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dwls_pkg::ST_FULL
      |-> rsp_occupancy == dwls_pkg::CNT_W'(dwls_pkg::DEPTH))
      else $error("full status with queue not full");

   // A find taken with no result pending is followed next cycle by a stall or a result
   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == dwls_pkg::FN_FIND &&
      !(rsp_valid && !rsp_stall) && !(rsp_valid && rsp_stall)
      |=> req_stall || rsp_valid)
      else $error("request taken while a find was still walking");

   // A stalled result stays valid with its status and occupancy held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_occupancy) &&
                                 $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind deque_with_linear_search dwls_chk u_dwls_chk (.*);
